@@ hw/rtl/plc_pkg.sv @@
// plc_pkg: shared types and constants for the positional list store
// command codes, field widths and the control bundle broadcast to the entry cells
// no dependencies
package plc_pkg;

    localparam int CMD_W          = 3;
    localparam int POS_W          = 7;
    localparam int VALUE_W        = 32;
    localparam int LEN_W          = 7;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_READ    = 3'd2,
        CMD_REPLACE = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             load;
        logic [POS_W-1:0] slot;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/plc_cell.sv @@
// plc_cell: one entry of the list chain
// holds, loads, or takes its left or right neighbor's entry each cycle
// depends on plc_pkg
module plc_cell #(
    parameter int INDEX  = 0,
    parameter int DATA_W = 32
) (
    input  logic                  i_clk,
    input  plc_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_W-1:0]     i_value,
    input  logic [DATA_W-1:0]     i_left,
    input  logic [DATA_W-1:0]     i_right,
    output logic [DATA_W-1:0]     o_data
);
    import plc_pkg::*;

    localparam logic [POS_W-1:0] MyIdx = POS_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            if (MyIdx > i_ctrl.slot) begin
                n_data = i_left;
            end else if (MyIdx == i_ctrl.slot) begin
                n_data = i_value;
            end
        end else if (i_ctrl.shift_down) begin
            if (MyIdx >= i_ctrl.slot) begin
                n_data = i_right;
            end
        end else if (i_ctrl.load && (MyIdx == i_ctrl.slot)) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/positional_list_store.sv @@
// positional_list_store: bounded list addressed by 1-based position
// result registered when taken; the cells from the slot on shift in parallel
// throughput: one command per cycle unless the output stalls
// reset: synchronous active-low, clears the length count and the output valid flag,
// entry contents are not reset; depends on plc_pkg and plc_cell
module positional_list_store #(
    parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plc_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [plc_pkg::CMD_W-1:0]     i_command,
    input  logic [plc_pkg::POS_W-1:0]     i_position,
    input  logic [plc_pkg::VALUE_W-1:0]   i_entry_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [plc_pkg::VALUE_W-1:0]   o_read_value,
    output logic [plc_pkg::LEN_W-1:0]     o_length,
    output logic                          o_empty_res
);
    import plc_pkg::*;

    localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CapVal = CNT_W'(CAPACITY);

    logic [SW-1:0] w_cells [CAPACITY];
    logic [SW-1:0] w_value;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               r_ok;
    logic [VALUE_W-1:0] r_read_value;
    logic [CNT_W-1:0]   r_length;

    logic               w_accept;
    logic [POS_W:0]     w_pos_ext;
    logic [POS_W:0]     w_cnt_ext;
    logic [POS_W-1:0]   w_slot;
    logic               w_pos_ok;
    logic               w_ins_ok;
    logic               n_ok;
    logic [VALUE_W-1:0] n_read_value;
    t_cell_ctrl         w_ctrl;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_value    = i_entry_value[SW-1:0];
    assign w_pos_ext  = {1'b0, i_position};
    assign w_cnt_ext  = (POS_W + 1)'(r_count);
    assign w_slot     = i_position - POS_W'(1);
    assign w_pos_ok   = (i_position != '0) && (w_pos_ext <= w_cnt_ext);
    assign w_ins_ok   = (i_position != '0) && (w_pos_ext <= w_cnt_ext + (POS_W + 1)'(1))
                        && (r_count < CapVal);

    always_comb begin
        n_count      = r_count;
        n_ok         = 1'b0;
        n_read_value = '0;
        w_ctrl       = '{shift_up: 1'b0, shift_down: 1'b0, load: 1'b0, slot: w_slot};
        unique case (t_cmd'(i_command))
            CMD_INSERT: begin
                if (w_ins_ok) begin
                    n_ok            = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                    w_ctrl.shift_up = w_accept;
                end
            end
            CMD_REMOVE: begin
                if (w_pos_ok) begin
                    n_ok              = 1'b1;
                    n_count           = r_count - CNT_W'(1);
                    w_ctrl.shift_down = w_accept;
                end
            end
            CMD_READ: begin
                if (w_pos_ok) begin
                    n_ok         = 1'b1;
                    n_read_value = VALUE_W'(w_cells[w_slot[IDX_W-1:0]]);
                end
            end
            CMD_REPLACE: begin
                if (w_pos_ok) begin
                    n_ok         = 1'b1;
                    n_read_value = VALUE_W'(w_cells[w_slot[IDX_W-1:0]]);
                    w_ctrl.load  = w_accept;
                end
            end
            CMD_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SW-1:0] w_left;
        logic [SW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cells[g];
        end else begin : g_mid_r
            assign w_right = w_cells[g+1];
        end
        plc_cell #(
            .INDEX  (g),
            .DATA_W (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cells[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_ok         <= n_ok;
            r_read_value <= n_read_value;
            r_length     <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_read_value;
    assign o_length     = LEN_W'(r_length);
    assign o_empty_res  = (r_length == '0);

endmodule

@@ dv/positional_list_store_tb.sv @@
// positional_list_store_tb: self-checking testbench for the positional list store
// predicts every transaction's result from a shadow copy of the list and compares fields
// depends on plc_pkg and positional_list_store
module positional_list_store_tb;
    import plc_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] entry_value;
    } t_list_cmd;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]   length;
        logic               empty_res;
    } t_list_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic [VALUE_W-1:0] i_entry_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_ok;
    logic [VALUE_W-1:0] o_read_value;
    logic [LEN_W-1:0]   o_length;
    logic               o_empty_res;

    t_list_cmd    list_cmd_q[$];
    t_list_result list_result_q[$];
    t_list_cmd    next_cmd;
    t_list_result want_result;

    logic [VALUE_W-1:0] list_mem [0:LIST_CAP-1];
    int                 list_len = 0;
    int                 gen_len = 0;
    int                 gen_issued = 0;

    int   in_idle_pct = 0;
    int   out_idle_pct = 0;
    logic out_hold = 1'b0;
    logic cmd_taken = 1'b0;
    int   taken_count = 0;
    int   cycle_count = 0;
    int   err_count = 0;

    positional_list_store u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_read_value  (o_read_value),
        .o_length      (o_length),
        .o_empty_res   (o_empty_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_result predict_result(input logic [CMD_W-1:0] cmd,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [VALUE_W-1:0] val);
        t_list_result res;
        int p;
        res = '0;
        p = pos;
        case (cmd)
            CMD_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < LIST_CAP) begin
                    for (int i = list_len; i >= p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (p >= 1 && p <= list_len) begin
                    for (int i = p; i < list_len; i++)
                        list_mem[i-1] = list_mem[i];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            CMD_READ: begin
                if (p >= 1 && p <= list_len) begin
                    res.read_value = list_mem[p-1];
                    res.ok = 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (p >= 1 && p <= list_len) begin
                    res.read_value = list_mem[p-1];
                    list_mem[p-1] = val;
                    res.ok = 1'b1;
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.length = list_len[LEN_W-1:0];
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    // shadow length at generation time keeps positions mostly in range
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic [VALUE_W-1:0] val);
        t_list_cmd item;
        item.command = cmd;
        item.position = pos[POS_W-1:0];
        item.entry_value = val;
        list_cmd_q.push_back(item);
        gen_issued++;
        case (cmd)
            CMD_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
            CMD_REMOVE: if (pos >= 1 && pos <= gen_len) gen_len--;
            CMD_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int in_range_pos(input int limit);
        if (limit < 1)
            return $urandom_range(0, POS_W'(1) << 0);
        return $urandom_range(1, limit);
    endfunction

    task automatic gen_random(input int n);
        int stop_at;
        int r;
        stop_at = gen_issued + n;
        while (gen_issued < stop_at) begin
            r = $urandom_range(0, 199);
            if (r == 0) begin
                // fill up to capacity, then push against the full list
                while (gen_len < LIST_CAP && gen_issued < stop_at)
                    queue_cmd(CMD_INSERT, $urandom_range(1, gen_len + 1), rand_value());
                queue_cmd(CMD_INSERT, gen_len + 1, rand_value());
                queue_cmd(CMD_INSERT, $urandom_range(1, 127), rand_value());
            end else begin
                r = r / 2;
                if (r < 35)
                    queue_cmd(CMD_INSERT, in_range_pos(gen_len + 1), rand_value());
                else if (r < 55)
                    queue_cmd(CMD_REMOVE, in_range_pos(gen_len), rand_value());
                else if (r < 75)
                    queue_cmd(CMD_READ, in_range_pos(gen_len), rand_value());
                else if (r < 88)
                    queue_cmd(CMD_REPLACE, in_range_pos(gen_len), rand_value());
                else if (r < 90)
                    queue_cmd(CMD_CLEAR, $urandom_range(0, 127), rand_value());
                else if (r < 97)
                    queue_cmd(CMD_W'($urandom_range(int'(CMD_INSERT), int'(CMD_CLEAR))),
                              $urandom_range(0, 127), rand_value());
                else
                    queue_cmd(CMD_W'($urandom_range(int'(CMD_UNKNOWN_FIRST),
                                                    int'(CMD_UNKNOWN_LAST))),
                              $urandom_range(0, 127), rand_value());
            end
        end
    endtask

    task automatic wait_drained();
        while (list_cmd_q.size() != 0 || i_in_valid || list_result_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("tb: mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || cmd_taken) begin
                if (list_cmd_q.size() == 0 || $urandom_range(0, 99) < in_idle_pct) begin
                    i_in_valid <= 1'b0;
                end else begin
                    next_cmd = list_cmd_q.pop_front();
                    i_command <= next_cmd.command;
                    i_position <= next_cmd.position;
                    i_entry_value <= next_cmd.entry_value;
                    i_in_valid <= 1'b1;
                end
            end
            cmd_taken = 1'b0;
            i_out_stall <= out_hold || ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (list_result_q.size() == 0) begin
                    report_mismatch("result with none expected", o_read_value, '0);
                end else begin
                    want_result = list_result_q.pop_front();
                    check_field("ok", VALUE_W'(o_ok), VALUE_W'(want_result.ok));
                    check_field("read_value", o_read_value, want_result.read_value);
                    check_field("length", VALUE_W'(o_length), VALUE_W'(want_result.length));
                    check_field("empty_res", VALUE_W'(o_empty_res),
                                VALUE_W'(want_result.empty_res));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                list_result_q.push_back(predict_result(i_command, i_position, i_entry_value));
                cmd_taken = 1'b1;
                taken_count++;
            end
        end
    end

    // long output hold so the block backs up and stalls its input
    initial begin
        while (taken_count < 150)
            @(posedge i_clk);
        out_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        out_hold = 1'b0;
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_cmd(CMD_READ, 1, '0);
        queue_cmd(CMD_REMOVE, 1, '0);
        queue_cmd(CMD_REPLACE, 1, 32'h1234_5678);
        queue_cmd(CMD_INSERT, 0, 32'h1111_1111);
        queue_cmd(CMD_INSERT, 2, 32'h2222_2222);
        queue_cmd(CMD_INSERT, 1, '1);
        queue_cmd(CMD_INSERT, 1, '0);
        queue_cmd(CMD_INSERT, 3, 32'hA5A5_A5A5);
        queue_cmd(CMD_INSERT, 2, 32'h5A5A_5A5A);
        for (int p = 1; p <= 5; p++)
            queue_cmd(CMD_READ, p, '0);
        queue_cmd(CMD_READ, 0, '0);
        queue_cmd(CMD_READ, 127, '1);
        queue_cmd(CMD_REPLACE, 2, 32'h0000_FFFF);
        queue_cmd(CMD_REMOVE, 2, '0);
        queue_cmd(CMD_REMOVE, 1, '0);
        queue_cmd(CMD_REMOVE, gen_len, '0);
        for (int c = CMD_UNKNOWN_FIRST; c <= CMD_UNKNOWN_LAST; c++)
            queue_cmd(CMD_W'(c), 1, '1);
        queue_cmd(CMD_CLEAR, 0, '0);
        queue_cmd(CMD_READ, 1, '0);
        queue_cmd(CMD_CLEAR, 127, '1);
        wait_drained();

        in_idle_pct = 34;
        out_idle_pct = 86;
        gen_random(430);
        wait_drained();

        in_idle_pct = 86;
        out_idle_pct = 34;
        gen_random(430);
        wait_drained();

        in_idle_pct = 0;
        out_idle_pct = 0;
        gen_random(440);
        wait_drained();

        repeat (8) @(negedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
